// ===== sv/lix_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lix_pkg
// Shared constants and types for the line intersection solver.
// ----------------------------------------------------------------------------
package lix_pkg;

    // Default coordinate format of the input points (signed Q8.8).
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Result format: signed Q16.16.
    localparam int OUT_FRAC = 16;
    localparam int QW       = 32;

    // Saturation limits of a 32-bit signed result.
    localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

    // Status that travels with each quotient out of the divider.
    typedef struct packed {
        logic ovf;  // quotient does not fit in 32 bits
        logic neg;  // quotient is negative
        logic nz;   // determinant is nonzero
    } t_div_stat;

endpackage

// ===== sv/lix_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lix_div
// Pipelined restoring divider: one quotient bit per stage, 32 quotient bits,
// with detection of quotients that do not fit in 32 bits.
// ----------------------------------------------------------------------------
module lix_div #(
    parameter int NW = 60,  // numerator width (signed)
    parameter int DW = 35   // denominator width (signed)
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [NW-1:0]  i_num,
    input  logic signed [DW-1:0]  i_den,
    output logic [lix_pkg::QW-1:0] o_quo,
    output lix_pkg::t_div_stat    o_stat
);

    localparam int QW = lix_pkg::QW;
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;
    localparam int NS = QW + 1;  // index of the last step stage

    // Stage 0: magnitudes and sign.
    logic [NW-1:0]     r_mag;
    logic [DW-1:0]     r_ud0;
    logic              r_neg0;
    logic              r_nz0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_ud0  <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
            r_neg0 <= i_num[NW-1] ^ i_den[DW-1];
            r_nz0  <= (i_den != '0);
        end
    end

    // Stages 1..NS: remainder, shifting numerator/quotient word and sideband.
    logic [DW-1:0]  r_rem [1:NS];
    logic [QW-1:0]  r_sh  [1:NS];
    logic [DW-1:0]  r_ud  [1:NS];
    logic           r_neg [1:NS];
    logic           r_nz  [1:NS];
    logic           r_ovf [1:NS];

    logic [HW-1:0]  w_hi;
    assign w_hi = r_mag[NW-1:QW];

    // Stage 1 starts the remainder from the upper numerator bits; if those
    // already reach the divisor, the quotient needs more than 32 bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[1] <= DW'(w_hi);
            r_sh[1]  <= r_mag[QW-1:0];
            r_ud[1]  <= r_ud0;
            r_neg[1] <= r_neg0;
            r_nz[1]  <= r_nz0;
            r_ovf[1] <= (CW'(w_hi) >= CW'(r_ud0)) && r_nz0;
        end
    end

    // One quotient bit per stage.
    for (genvar k = 2; k <= NS; k++) begin : g_step
        logic [DW:0] w_t;
        logic        w_ge;
        assign w_t  = {r_rem[k-1], r_sh[k-1][QW-1]};
        assign w_ge = (w_t >= {1'b0, r_ud[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? DW'(w_t - {1'b0, r_ud[k-1]}) : DW'(w_t);
                r_sh[k]  <= {r_sh[k-1][QW-2:0], w_ge};
                r_ud[k]  <= r_ud[k-1];
                r_neg[k] <= r_neg[k-1];
                r_nz[k]  <= r_nz[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo       = r_sh[NS];
    assign o_stat.ovf  = r_ovf[NS];
    assign o_stat.neg  = r_neg[NS];
    assign o_stat.nz   = r_nz[NS];

    // The final remainder is not needed by the result.
    logic w_unused;
    assign w_unused = ^r_rem[NS];

endmodule

// ===== sv/line_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_intersection
// Intersection of two lines given by point pairs, solved by Cramer's rule
// in exact fixed point, with a signed Q16.16 saturated result.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake           | Payload
// input    | in        | i_valid / o_ready   | i_line_{a,b}_{start,end}_{x,y}
// result   | out       | o_valid / i_ready   | o_cross_x, o_cross_y,
//          |           |                     | o_intersects, o_overflow
//
// One item enters per cycle while o_ready is high. Five stages form the
// determinants, 34 divider stages produce the quotient (magnitudes, overflow
// check, then one quotient bit per stage for 32 stages, both coordinates side
// by side), one register holds the result. A skid register behind the output
// takes one result when the output stalls. Synchronous reset clears the valid
// bits only; a stall freezes the whole pipeline once the skid register is
// occupied.
// ----------------------------------------------------------------------------
module line_intersection #(
    parameter int COORD_BITS = lix_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lix_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_line_a_start_x,
    input  logic signed [COORD_BITS-1:0] i_line_a_start_y,
    input  logic signed [COORD_BITS-1:0] i_line_a_end_x,
    input  logic signed [COORD_BITS-1:0] i_line_a_end_y,
    input  logic signed [COORD_BITS-1:0] i_line_b_start_x,
    input  logic signed [COORD_BITS-1:0] i_line_b_start_y,
    input  logic signed [COORD_BITS-1:0] i_line_b_end_x,
    input  logic signed [COORD_BITS-1:0] i_line_b_end_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [31:0]           o_cross_x,
    output logic signed [31:0]           o_cross_y,
    output logic                         o_intersects,
    output logic                         o_overflow
);

    localparam int QW  = lix_pkg::QW;
    localparam int C   = COORD_BITS;
    localparam int SH  = lix_pkg::OUT_FRAC - FRAC_BITS;
    localparam int AW  = C + 1;          // point differences
    localparam int PW  = 2 * C + 3;      // determinant and right-hand sides
    localparam int MW  = PW + AW;        // second-level products
    localparam int NW  = MW + 1 + SH;    // scaled numerators
    localparam int DS  = QW + 2;         // divider stages
    localparam int NP  = 5 + DS;         // pipeline valid bits

    // Pipeline control: everything advances while the skid register is free.
    logic          w_en;
    logic [NP-1:0] r_v;
    logic          r_o_v;
    logic          r_s_v;

    assign w_en    = !r_s_v;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NP-2:0], i_valid};
        end
    end

    // Stage 1: line direction terms, keep the start points.
    logic signed [AW-1:0] r1_a11, r1_a12, r1_a21, r1_a22;
    logic signed [C-1:0]  r1_ax0, r1_ay0, r1_bx0, r1_by0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a11 <= AW'(i_line_a_start_y) - AW'(i_line_a_end_y);
            r1_a12 <= AW'(i_line_a_end_x) - AW'(i_line_a_start_x);
            r1_a21 <= AW'(i_line_b_start_y) - AW'(i_line_b_end_y);
            r1_a22 <= AW'(i_line_b_end_x) - AW'(i_line_b_start_x);
            r1_ax0 <= i_line_a_start_x;
            r1_ay0 <= i_line_a_start_y;
            r1_bx0 <= i_line_b_start_x;
            r1_by0 <= i_line_b_start_y;
        end
    end

    // Stage 2: first-level products.
    logic signed [PW-1:0] r2_p1, r2_p2, r2_q1, r2_q2, r2_q3, r2_q4;
    logic signed [AW-1:0] r2_a11, r2_a12, r2_a21, r2_a22;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_p1  <= PW'(r1_a11) * PW'(r1_a22);
            r2_p2  <= PW'(r1_a12) * PW'(r1_a21);
            r2_q1  <= PW'(r1_ax0) * PW'(r1_a11);
            r2_q2  <= PW'(r1_ay0) * PW'(r1_a12);
            r2_q3  <= PW'(r1_bx0) * PW'(r1_a21);
            r2_q4  <= PW'(r1_by0) * PW'(r1_a22);
            r2_a11 <= r1_a11;
            r2_a12 <= r1_a12;
            r2_a21 <= r1_a21;
            r2_a22 <= r1_a22;
        end
    end

    // Stage 3: determinant and right-hand sides.
    logic signed [PW-1:0] r3_d, r3_b1, r3_b2;
    logic signed [AW-1:0] r3_a11, r3_a12, r3_a21, r3_a22;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_d   <= r2_p1 - r2_p2;
            r3_b1  <= r2_q1 + r2_q2;
            r3_b2  <= r2_q3 + r2_q4;
            r3_a11 <= r2_a11;
            r3_a12 <= r2_a12;
            r3_a21 <= r2_a21;
            r3_a22 <= r2_a22;
        end
    end

    // Stage 4: second-level products for the numerators.
    logic signed [MW-1:0] r4_m1, r4_m2, r4_m3, r4_m4;
    logic signed [PW-1:0] r4_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_m1 <= MW'(r3_b1) * MW'(r3_a22);
            r4_m2 <= MW'(r3_b2) * MW'(r3_a12);
            r4_m3 <= MW'(r3_a11) * MW'(r3_b2);
            r4_m4 <= MW'(r3_a21) * MW'(r3_b1);
            r4_d  <= r3_d;
        end
    end

    // Stage 5: numerators scaled to the Q16.16 result.
    logic signed [NW-1:0] r5_nx, r5_ny;
    logic signed [PW-1:0] r5_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_nx <= (NW'(r4_m1) - NW'(r4_m2)) <<< SH;
            r5_ny <= (NW'(r4_m3) - NW'(r4_m4)) <<< SH;
            r5_d  <= r4_d;
        end
    end

    // Dividers for both coordinates.
    logic [QW-1:0]       w_qx, w_qy;
    lix_pkg::t_div_stat  w_sx, w_sy;

    lix_div #(.NW(NW), .DW(PW)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r5_nx),
        .i_den  (r5_d),
        .o_quo  (w_qx),
        .o_stat (w_sx)
    );

    lix_div #(.NW(NW), .DW(PW)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r5_ny),
        .i_den  (r5_d),
        .o_quo  (w_qy),
        .o_stat (w_sy)
    );

    // Sign, saturation and the parallel case.
    logic [QW-1:0] w_x, w_y;
    logic          w_ovx, w_ovy, w_nz, w_ovf;

    always_comb begin
        w_ovx = w_sx.ovf || (w_sx.neg ? (w_qx[QW-1] && (w_qx[QW-2:0] != '0))
                                       : w_qx[QW-1]);
        w_ovy = w_sy.ovf || (w_sy.neg ? (w_qy[QW-1] && (w_qy[QW-2:0] != '0))
                                       : w_qy[QW-1]);
        w_nz  = w_sx.nz;
        if (w_ovx) begin
            w_x = w_sx.neg ? lix_pkg::SAT_NEG : lix_pkg::SAT_POS;
        end else begin
            w_x = w_sx.neg ? -w_qx : w_qx;
        end
        if (w_ovy) begin
            w_y = w_sy.neg ? lix_pkg::SAT_NEG : lix_pkg::SAT_POS;
        end else begin
            w_y = w_sy.neg ? -w_qy : w_qy;
        end
        if (!w_nz) begin
            w_x = '0;
            w_y = '0;
        end
        w_ovf = w_nz && (w_ovx || w_ovy);
    end

    // Output register and skid register.
    logic [QW-1:0] r_o_x, r_o_y, r_s_x, r_s_y;
    logic          r_o_nz, r_o_ovf, r_s_nz, r_s_ovf;
    logic          w_pv, w_free;

    assign w_pv   = r_v[NP-1];
    assign w_free = !r_o_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (w_free) begin
            if (r_s_v) begin
                r_o_v <= 1'b1;
                r_s_v <= 1'b0;
            end else begin
                r_o_v <= w_pv;
            end
        end else if (w_pv && w_en) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_s_v) begin
                r_o_x   <= r_s_x;
                r_o_y   <= r_s_y;
                r_o_nz  <= r_s_nz;
                r_o_ovf <= r_s_ovf;
            end else begin
                r_o_x   <= w_x;
                r_o_y   <= w_y;
                r_o_nz  <= w_nz;
                r_o_ovf <= w_ovf;
            end
        end else if (w_en) begin
            r_s_x   <= w_x;
            r_s_y   <= w_y;
            r_s_nz  <= w_nz;
            r_s_ovf <= w_ovf;
        end
    end

    assign o_valid      = r_o_v;
    assign o_cross_x    = r_o_x;
    assign o_cross_y    = r_o_y;
    assign o_intersects = r_o_nz;
    assign o_overflow   = r_o_ovf;

    // The second divider's determinant flag matches the first one.
    logic w_unused;
    assign w_unused = w_sy.nz;

endmodule

// ===== sv/lix_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lix_check
// Port-level checks of the line intersection solver's result channel.
// ----------------------------------------------------------------------------
module lix_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_cross_x,
    input logic signed [31:0] o_cross_y,
    input logic               o_intersects,
    input logic               o_overflow
);

    // A result that waits keeps its coordinates and its overflow flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cross_x)
            && $stable(o_cross_y) && $stable(o_overflow))
        else $error("result changed while stalled");

    // Parallel lines report the origin without overflow.
    a_par: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_intersects |-> o_cross_x == 0 && o_cross_y == 0 && !o_overflow)
        else $error("parallel result not zero");

    // Overflow means at least one coordinate sits at a saturation limit.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_cross_x == 32'sh7FFFFFFF
            || o_cross_x == 32'sh80000000 || o_cross_y == 32'sh7FFFFFFF
            || o_cross_y == 32'sh80000000)
        else $error("overflow without saturated coordinate");

    // No result is shown right after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind line_intersection lix_check u_lix_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_cross_x    (o_cross_x),
    .o_cross_y    (o_cross_y),
    .o_intersects (o_intersects),
    .o_overflow   (o_overflow)
);
